// ===== rtl/rcpf_pkg.sv =====
// Shared types and sizing constants for the radius-connected point filter.
// No dependencies; imported by the controller, the datapath and the top level.
package rcpf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int RES_LIMIT  = 64;
  localparam int RES_W      = $clog2(RES_LIMIT + 1);
  localparam int OUT_IDX_W  = 6;
  localparam int LINK_W     = 34;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int CMP_W      = (SUM_W > LINK_W) ? SUM_W : LINK_W;
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int IN_DATA_W  = ((PT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_IDX_W + PT_W + 7) / 8) * 8;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  // x sits in the lowest bits
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan_go;
    logic pop_rd;
    logic fetch;
    logic ref_load;
    logic emit;
    logic emit_none;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic stack_empty;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/rcpf_ctrl.sv =====
// Sequencer for the point filter: load, seed gather, then pop/gather/emit loop, or a not-found result.
// Depends on rcpf_pkg for the command and status structs.
module rcpf_ctrl import rcpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_SCAN,
    ST_POP,
    ST_FETCH,
    ST_REF,
    ST_SCAN,
    ST_EMIT,
    ST_NONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == REQ_START) begin
            cmd.start   = 1'b1;
            cmd.scan_go = 1'b1;
            state_next  = ST_SEED_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SEED_SCAN: begin
        if (!status.scan_busy) begin
          state_next = status.stack_empty ? ST_NONE : ST_POP;
        end
      end
      ST_POP: begin
        cmd.pop_rd = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_REF;
      end
      ST_REF: begin
        cmd.ref_load = 1'b1;
        cmd.scan_go  = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.scan_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the point
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.stack_empty ? ST_IDLE : ST_POP;
        end
      end
      ST_NONE: begin
        if (status.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rcpf_datapath.sv =====
// Point store, pending stack, distance pipeline and output register.
// Depends on rcpf_pkg; driven by rcpf_ctrl through dp_cmd_t.
module rcpf_datapath import rcpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [LINK_W-1:0]     cfg_data,
  input  point_t                in_point,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [OUT_IDX_W-1:0]  out_idx,
  output point_t                out_point,
  output logic                  out_last
);

  logic [LINK_W-1:0] link_dist_sq;
  logic [CNT_W-1:0]  point_count;
  logic [CNT_W-1:0]  count_dec;
  logic [IDX_W-1:0]  last_idx;

  point_t            store_mem [MAX_POINTS];
  point_t            rd_data;
  logic [IDX_W-1:0]  rd_addr;

  logic [IDX_W-1:0]  stack_mem [MAX_POINTS];
  logic [CNT_W-1:0]  stack_depth;
  logic [CNT_W-1:0]  stack_dec;
  logic [IDX_W-1:0]  pop_v;

  logic [MAX_POINTS-1:0] unvisited;
  point_t            ref_pt;

  logic              scan_act;
  logic [IDX_W-1:0]  scan_i;
  logic              v1, v2, v3;
  logic [IDX_W-1:0]  idx1, idx2, idx3;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [SQ_W-1:0]   sqx, sqy, sqz;
  logic [SUM_W-1:0]  dist_sum;
  logic              hit;

  logic [RES_W-1:0]  res_n;
  logic              res_room;

  assign count_dec = point_count - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];
  assign stack_dec = stack_depth - CNT_W'(1);
  assign rd_addr   = cmd.fetch ? pop_v : scan_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_dist_sq <= '0;
    end else if (cfg_valid) begin
      link_dist_sq <= cfg_data;
    end
  end

  // point store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && (point_count < CNT_W'(MAX_POINTS))) begin
      store_mem[point_count[IDX_W-1:0]] <= in_point;
    end
    rd_data <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.emit_none || (cmd.emit && status.stack_empty)) begin
      point_count <= '0;
    end else if (cmd.load && (point_count < CNT_W'(MAX_POINTS))) begin
      point_count <= point_count + CNT_W'(1);
    end
  end

  // scan address issue and valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      scan_i   <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
    end else begin
      if (cmd.scan_go) begin
        scan_act <= (point_count != '0);
        scan_i   <= '0;
      end else if (scan_act) begin
        scan_act <= (scan_i != last_idx);
        scan_i   <= scan_i + IDX_W'(1);
      end
      v1 <= scan_act;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= scan_i;
    idx2 <= idx1;
    idx3 <= idx2;
    dx   <= $signed({rd_data.x[COORD_BITS-1], rd_data.x})
          - $signed({ref_pt.x[COORD_BITS-1], ref_pt.x});
    dy   <= $signed({rd_data.y[COORD_BITS-1], rd_data.y})
          - $signed({ref_pt.y[COORD_BITS-1], ref_pt.y});
    dz   <= $signed({rd_data.z[COORD_BITS-1], rd_data.z})
          - $signed({ref_pt.z[COORD_BITS-1], ref_pt.z});
    sqx  <= dx * dx;
    sqy  <= dy * dy;
    sqz  <= dz * dz;
  end

  // squares are never negative, so they add as unsigned
  assign dist_sum = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
  assign hit      = v3 && (CMP_W'(dist_sum) <= CMP_W'(link_dist_sq)) && unvisited[idx3];

  // pending stack: push from the pipeline, pop between scans
  always_ff @(posedge clk) begin
    if (hit) begin
      stack_mem[stack_depth[IDX_W-1:0]] <= idx3;
    end
    if (cmd.pop_rd) begin
      pop_v <= stack_mem[stack_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth <= '0;
    end else if (cmd.start) begin
      stack_depth <= '0;
    end else if (hit) begin
      stack_depth <= stack_depth + CNT_W'(1);
    end else if (cmd.pop_rd) begin
      stack_depth <= stack_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      unvisited <= '1;
    end else if (hit) begin
      unvisited[idx3] <= 1'b0;
    end
    if (cmd.start) begin
      ref_pt <= in_point;
    end else if (cmd.ref_load) begin
      ref_pt <= rd_data;
    end
  end

  assign res_room = (res_n < RES_W'(RES_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_n <= '0;
    end else if (cmd.start) begin
      res_n <= '0;
    end else if (cmd.emit && res_room) begin
      res_n <= res_n + RES_W'(1);
    end
  end

  // output register; drop points past the result limit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && res_room) begin
      out_valid <= 1'b1;
    end else if (cmd.emit_none) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && res_room) begin
      out_found <= 1'b1;
      out_idx   <= OUT_IDX_W'(pop_v);
      out_point <= ref_pt;
      out_last  <= status.stack_empty || (res_n == RES_W'(RES_LIMIT - 1));
    end else if (cmd.emit_none) begin
      out_found <= 1'b0;
      out_idx   <= '0;
      out_point <= '0;
      out_last  <= 1'b1;
    end
  end

  assign status.scan_busy   = scan_act | v1 | v2 | v3;
  assign status.stack_empty = (stack_depth == '0);
  assign status.out_free    = !out_valid || out_ready;

endmodule

// ===== rtl/radius_connected_point_filter.sv =====
// Top level of the radius-connected point filter: ports, packing, checks.
// Depends on rcpf_pkg, rcpf_ctrl and rcpf_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: x,y,z; tuser: req_type
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: index,x,y,z; tuser: found;
//                                                      tlast: last
//  cfg       in         cfg_valid / cfg_ready          cfg_data: link_dist_sq
//
// Loads stream at one per cycle while the filter is idle.
// A start runs one gather pass for the seed and one for every connected point;
// each pass walks the point store through its single read port, and every
// point also goes through pop and emit.
// Reset is synchronous and needs no clearing pass; the point count is cleared once a search ends.
// A stalled result waits in the output register while the next gather runs.
module radius_connected_point_filter import rcpf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // coord_x, coord_y, coord_z
  input  logic                   s_axis_tuser,  // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // point_index, out_x, out_y, out_z
  output logic                   m_axis_tuser,  // found
  output logic                   m_axis_tlast,  // last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LINK_W-1:0]      cfg_data
);

  dp_cmd_t               cmd;
  dp_status_t            status;
  point_t                in_point;
  point_t                out_point;
  logic [OUT_IDX_W-1:0]  out_idx;
  logic                  in_ready;

  assign in_point      = point_t'(s_axis_tdata[PT_W-1:0]);
  assign s_axis_tready = in_ready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = OUT_DATA_W'({out_point, out_idx});

  rcpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (in_ready),
    .in_kind  (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  rcpf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_point  (in_point),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_found (m_axis_tuser),
    .out_idx   (out_idx),
    .out_point (out_point),
    .out_last  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_accept_scan_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !status.scan_busy)
    else $error("transaction accepted while a gather pass is in flight");

  a_emit_after_gather: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_none) |-> !status.scan_busy)
    else $error("result issued before the gather pass finished");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> !status.stack_empty)
    else $error("pop from an empty pending stack");

  a_none_only_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_none |-> (status.stack_empty && !cmd.emit))
    else $error("not-found result while points are pending");
`endif

endmodule
